// ===== sv/plti_pkg.sv =====
// Package: types and constants for the piecewise linear table lookup.
`timescale 1ns / 1ps
`default_nettype none
package plti_pkg;
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REG_CONST_MODE = 2'd0;
  localparam logic [1:0] REG_COND_COUNT = 2'd1;
  localparam logic [1:0] REG_CAP_COUNT  = 2'd2;

  localparam logic [1:0] REGION_LOW   = 2'd0;
  localparam logic [1:0] REGION_INTERP = 2'd1;
  localparam logic [1:0] REGION_HIGH  = 2'd2;
  localparam logic [1:0] REGION_CONST = 2'd3;

  typedef struct packed {
    logic               func;
    logic               table_select;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_temp;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_temp;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         region;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/plti_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module plti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sv/piecewise_linear_table_interp.sv =====
// Top level: two breakpoint tables with linear interpolation lookup.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Requests enter on req when start is high and busy is low. A load
//   (func 0) writes one breakpoint of the chosen table and returns nothing;
//   busy stays low for it and the next request may follow at once.
//   A query (func 1) raises busy and gives one result on res with done high
//   for exactly one cycle. The receiver cannot hold results off.
//   Configuration is written on cfg_we/cfg_index/cfg_data; the user must do
//   so only while no query is in progress, as the block does not enforce it.
//   A query scans the breakpoints of the chosen table in order through S_SCANA
//   and S_SCANB. Constant mode and a query clamped low end at the first entry;
//   a query clamps high either when the scan reaches the last breakpoint in use
//   or at the last-breakpoint check in S_FETA. An interpolated query goes on
//   through a neighbor fetch (S_FETA, S_FETB, S_FETC), a serial shift-add
//   multiply and a restoring divide, one quotient bit per cycle. The serial
//   multiply and divide make interpolated queries the longest. The next
//   request may be accepted at the edge that ends the done cycle.
//   Reset: a clearing pass in S_CLEAR writes zero to every entry of both
//   tables; busy is high during it. Registers reset to constant mode, counts 1.
module piecewise_linear_table_interp
  import plti_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t req,
  output logic          done,
  output result_t       res,
  input  wire logic     cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_data
);
  localparam int IW = $clog2(ENTRIES);
  localparam int AW = IW + 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCANA = 4'd2;
  localparam logic [3:0] S_SCANB = 4'd3;
  localparam logic [3:0] S_FETA  = 4'd4;
  localparam logic [3:0] S_FETB  = 4'd5;
  localparam logic [3:0] S_FETC  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;
  logic       constant_mode;
  logic [4:0] cond_count, cap_count;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wt, wv, rt, rv;

  plti_ram #(.WIDTH(32), .DEPTH(2 * ENTRIES)) u_temps (
    .clk(clk), .we(we), .addr(addr), .wdata(wt), .rdata(rt));
  plti_ram #(.WIDTH(32), .DEPTH(2 * ENTRIES)) u_values (
    .clk(clk), .we(we), .addr(addr), .wdata(wv), .rdata(rv));

  logic          tsel;
  logic [IW-1:0] idx;
  logic [CW-1:0] n;
  logic signed [31:0] qt, v1, t2, v2;
  logic [AW-1:0] clr;
  logic [32:0]   mag, dt, span;
  logic          neg;
  logic [63:0]   prod;
  logic [32:0]   mcand;
  logic [5:0]    cnt;
  logic [32:0]   rem;
  logic [63:0]   quo;
  logic [6:0]    dcnt;
  logic [1:0]    region;
  logic signed [31:0] value;

  logic [4:0]    cnt_sel;
  logic [CW-1:0] n_used;
  logic [CW-1:0] last;
  logic [33:0]   trial;

  always_comb begin
    cnt_sel = req.table_select ? cap_count : cond_count;
    if (cnt_sel == 5'd0) n_used = CW'(1);
    else if (32'(cnt_sel) > ENTRIES) n_used = CW'(ENTRIES);
    else n_used = CW'(cnt_sel);
    last  = n - CW'(1);
    trial = {rem, quo[63]} - {1'b0, span};
  end

  always_comb begin
    we   = 1'b0;
    addr = {tsel, idx};
    wt   = '0;
    wv   = '0;
    if (state == S_CLEAR) begin
      we   = 1'b1;
      addr = clr;
    end else if (state == S_IDLE && start && req.func == FUNC_LOAD) begin
      we   = (32'(req.entry_index) < ENTRIES);
      addr = {req.table_select, req.entry_index[IW-1:0]};
      wt   = req.entry_temp;
      wv   = req.entry_value;
    end else if (state == S_IDLE && start) begin
      addr = {req.table_select, IW'(0)};
    end else if (state == S_FETA || state == S_FETB) begin
      addr = {tsel, idx - IW'(1)};
    end else if (state == S_SCANB && $signed(rt) >= qt && idx != '0) begin
      addr = {tsel, last[IW-1:0]};
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      constant_mode <= 1'b1;
      cond_count    <= 5'd1;
      cap_count     <= 5'd1;
      done          <= 1'b0;
      mcand         <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_CONST_MODE: constant_mode <= cfg_data[0];
          REG_COND_COUNT: cond_count    <= cfg_data;
          REG_CAP_COUNT:  cap_count     <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (32'(clr) == 2 * ENTRIES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start && req.func == FUNC_QUERY) begin
            tsel  <= req.table_select;
            idx   <= '0;
            qt    <= req.query_temp;
            n     <= n_used;
            state <= S_SCANB;
          end
        end
        S_SCANA: state <= S_SCANB;
        S_SCANB: begin
          if (constant_mode) begin
            value <= rv; region <= REGION_CONST; state <= S_OUT;
          end else if ($signed(rt) >= qt) begin
            if (idx == '0) begin
              value <= rv; region <= REGION_LOW; state <= S_OUT;
            end else begin
              t2 <= rt; v2 <= rv; state <= S_FETA;
            end
          end else if ({1'b0, idx} == last) begin
            value <= rv; region <= REGION_HIGH; state <= S_OUT;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_SCANA;
          end
        end
        S_FETA: begin
          // last breakpoint in use is on rt/rv here
          if (qt > $signed(rt)) begin
            value <= rv; region <= REGION_HIGH; state <= S_OUT;
          end else begin
            state <= S_FETB;
          end
        end
        S_FETB: state <= S_FETC;
        S_FETC: begin
          v1 <= rv;
          dt   <= 33'({qt[31], qt} - {rt[31], rt});
          span <= 33'({t2[31], t2} - {rt[31], rt});
          if ($signed({v2[31], v2}) < $signed({rv[31], rv})) begin
            neg <= 1'b1; mag <= {rv[31], rv} - {v2[31], v2};
          end else begin
            neg <= 1'b0; mag <= {v2[31], v2} - {rv[31], rv};
          end
          prod  <= '0;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // shift-add, one multiplier bit per cycle, msb first
          prod  <= (prod << 1) + (dt[31 - cnt[4:0]] ? {32'd0, mag[31:0]} : 64'd0);
          cnt   <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            dcnt  <= '0;
            rem   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == 7'd0 && mcand == '0) quo <= prod;
          if (dcnt != 7'd0 || mcand != '0) begin
            if (!trial[33]) begin
              rem <= trial[32:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= {rem[31:0], quo[63]};
              quo <= {quo[62:0], 1'b0};
            end
            dcnt <= dcnt + 7'd1;
            if (dcnt == 7'd64) begin
              value <= neg ? v1 - quo[31:0] : v1 + quo[31:0];
              region <= REGION_INTERP;
              state <= S_OUT;
            end
          end
          mcand <= 33'd1;
        end
        S_OUT: begin
          done  <= 1'b1;
          res   <= '{value: value, region: region};
          mcand <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_piecewise_linear_table_interp.sv =====
// Testbench: table lookup with interpolation, checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb_piecewise_linear_table_interp;
  import plti_pkg::*;

  localparam int NUM_ENTRIES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t req = '0;
  logic done;
  result_t res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  piecewise_linear_table_interp #(.ENTRIES(NUM_ENTRIES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  logic signed [31:0] bp_temp [2*NUM_ENTRIES];
  logic signed [31:0] bp_value [2*NUM_ENTRIES];
  logic const_mode;
  logic [4:0] cond_count, cap_count;
  result_t lookup_q [$];
  int errors = 0;

  typedef struct {
    request_t r;
    bit has_exp;
    result_t exp;
  } stim_row_t;

  function automatic result_t predict_lookup(request_t r);
    result_t o;
    int base, n, i;
    logic signed [63:0] t, t1, t2, v1, v2, dv, rv;
    logic [63:0] dt, span, mag, q;
    base = r.table_select ? NUM_ENTRIES : 0;
    if (const_mode) begin
      o.value = bp_value[base];
      o.region = REGION_CONST;
      return o;
    end
    n = r.table_select ? cap_count : cond_count;
    if (n == 0) n = 1;
    if (n > NUM_ENTRIES) n = NUM_ENTRIES;
    t = r.query_temp;
    for (i = 0; i < n; i++)
      if ($signed(64'(bp_temp[base+i])) >= t) break;
    if (i == 0) begin
      o.value = bp_value[base];
      o.region = REGION_LOW;
    end else if (t > bp_temp[base+n-1]) begin
      o.value = bp_value[base+n-1];
      o.region = REGION_HIGH;
    end else begin
      t1 = bp_temp[base+i-1];
      t2 = bp_temp[base+i];
      v1 = bp_value[base+i-1];
      v2 = bp_value[base+i];
      dt = t - t1;
      span = t2 - t1;
      dv = v2 - v1;
      mag = dv < 0 ? -dv : dv;
      q = (mag * dt) / span;
      rv = dv < 0 ? v1 - $signed(q) : v1 + $signed(q);
      o.value = rv[31:0];
      o.region = REGION_INTERP;
    end
    return o;
  endfunction

  // result check
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (lookup_q.size() == 0) begin
        $display("%0t unexpected result: actual value %h region %0d",
                 $time, res.value, res.region);
        errors++;
      end else begin
        e = lookup_q.pop_front();
        if (res.value !== e.value || res.region !== e.region) begin
          $display("%0t mismatch: expected value %h region %0d, actual value %h region %0d",
                   $time, e.value, e.region, res.value, res.region);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CONST_MODE: const_mode = data[0];
      REG_COND_COUNT: cond_count = data;
      REG_CAP_COUNT:  cap_count = data;
      default: ;
    endcase
  endtask

  // drive one request; start is lowered between issues only when gap > 0, so back-to-back issues keep it high
  task automatic issue(request_t r, bit has_exp, result_t exp_r, int gap);
    result_t p;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    req = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_lookup(r);
    if (r.func == FUNC_LOAD) begin
      if (r.entry_index < NUM_ENTRIES) begin
        bp_temp[(r.table_select ? NUM_ENTRIES : 0) + r.entry_index] = r.entry_temp;
        bp_value[(r.table_select ? NUM_ENTRIES : 0) + r.entry_index] = r.entry_value;
      end
    end else begin
      lookup_q.push_back(has_exp ? exp_r : p);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (lookup_q.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic request_t mk(logic f, logic ts, logic [3:0] ix,
                                  logic [31:0] et, logic [31:0] ev, logic [31:0] qt);
    request_t r;
    r.func = f; r.table_select = ts; r.entry_index = ix;
    r.entry_temp = et; r.entry_value = ev; r.query_temp = qt;
    return r;
  endfunction

  function automatic logic [31:0] rand_temp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 64) - 32;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic result_t rr(logic [31:0] v, logic [1:0] g);
    result_t o;
    o.value = v; o.region = g;
    return o;
  endfunction

  stim_row_t directed [$];

  initial begin
    request_t r;
    int k, tsel, cnt;
    logic signed [31:0] tv;
    for (k = 0; k < 2*NUM_ENTRIES; k++) begin
      bp_temp[k] = '0;
      bp_value[k] = '0;
    end
    const_mode = 1'b1;
    cond_count = 5'd1;
    cap_count = 5'd1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // constant mode after reset, then loads and extremes
    directed.push_back('{mk(FUNC_QUERY, 0, 0, 0, 0, 32'h8000_0000), 1, rr(0, REGION_CONST)});
    directed.push_back('{mk(FUNC_LOAD, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0), 0, rr(0, 0)});
    directed.push_back('{mk(FUNC_LOAD, 0, 1, 32'h0000_0000, 32'h8000_0000, 0), 0, rr(0, 0)});
    directed.push_back('{mk(FUNC_LOAD, 0, 2, 32'h7fff_ffff, 32'h0001_0000, 0), 0, rr(0, 0)});
    directed.push_back('{mk(FUNC_LOAD, 1, 15, 32'hffff_ffff, 32'hffff_ffff, 0), 0, rr(0, 0)});
    directed.push_back('{mk(FUNC_LOAD, 1, 0, 32'hffff_0000, 32'h1234_5678, 0), 0, rr(0, 0)});
    directed.push_back('{mk(FUNC_QUERY, 0, 0, 0, 0, 32'h7fff_ffff), 1, rr(32'h7fff_ffff, REGION_CONST)});
    directed.push_back('{mk(FUNC_QUERY, 1, 15, 0, 0, 0), 1, rr(32'h1234_5678, REGION_CONST)});
    foreach (directed[i]) issue(directed[i].r, directed[i].has_exp, directed[i].exp, 0);
    drain();
    directed.delete();

    write_reg(REG_CONST_MODE, 5'd0);
    write_reg(REG_COND_COUNT, 5'd3);
    write_reg(REG_CAP_COUNT, 5'd0);
    directed.push_back('{mk(FUNC_QUERY, 0, 0, 0, 0, 32'h8000_0000), 1, rr(32'h7fff_ffff, REGION_LOW)});
    directed.push_back('{mk(FUNC_QUERY, 0, 0, 0, 0, 32'h7fff_ffff), 1, rr(32'h0001_0000, REGION_INTERP)});
    directed.push_back('{mk(FUNC_QUERY, 0, 0, 0, 0, 32'h0000_0000), 1, rr(32'h8000_0000, REGION_INTERP)});
    directed.push_back('{mk(FUNC_QUERY, 0, 0, 0, 0, 32'hc000_0000), 0, rr(0, 0)});
    directed.push_back('{mk(FUNC_QUERY, 0, 0, 0, 0, 32'h3fff_ffff), 0, rr(0, 0)});
    directed.push_back('{mk(FUNC_QUERY, 1, 0, 0, 0, 32'h7fff_ffff), 1, rr(32'h1234_5678, REGION_HIGH)});
    directed.push_back('{mk(FUNC_QUERY, 1, 0, 0, 0, 32'h8000_0000), 1, rr(32'h1234_5678, REGION_LOW)});
    foreach (directed[i]) issue(directed[i].r, directed[i].has_exp, directed[i].exp, 0);
    drain();
    write_reg(REG_COND_COUNT, 5'd31);
    write_reg(REG_CAP_COUNT, 5'd16);
    issue(mk(FUNC_QUERY, 0, 0, 0, 0, 32'h7fff_ffff), 0, rr(0, 0), 0);
    issue(mk(FUNC_QUERY, 1, 0, 0, 0, 32'h0000_0001), 0, rr(0, 0), 1);
    drain();

    // random phases: reload tables with mostly ascending temperatures, then mostly queries
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_CONST_MODE, (ph % 6 == 5) ? 5'd1 : 5'd0);
      cnt = (ph == 0) ? 1 : (ph == 1) ? 16 : $urandom_range(1, 16);
      write_reg(REG_COND_COUNT, ph == 2 ? 5'd0 : 5'(cnt));
      write_reg(REG_CAP_COUNT, ph == 3 ? 5'd31 : 5'($urandom_range(0, 31)));
      for (tsel = 0; tsel < 2; tsel++) begin
        tv = $urandom_range(0, 4) == 0 ? 32'h8000_0000 : -32'sd200000;
        for (k = 0; k < NUM_ENTRIES; k++) begin
          if ($urandom_range(0, 9) == 0) tv = $urandom();
          else tv = tv + $urandom_range(0, 40000);
          issue(mk(FUNC_LOAD, tsel[0], k[3:0], tv, $urandom(), $urandom()), 0, rr(0, 0),
                $urandom_range(0, 10));
        end
      end
      for (k = 0; k < 118; k++) begin
        if ($urandom_range(0, 9) == 0)
          r = mk(FUNC_LOAD, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 rand_temp(), $urandom(), $urandom());
        else
          r = mk(FUNC_QUERY, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 $urandom(), $urandom(), rand_temp());
        issue(r, 0, rr(0, 0), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
      end
      drain();
    end

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
